// ----- rtl/core/sjfq_pkg.sv -----
// shared types and constants for the sorted ready queue
`timescale 1ns / 1ps

package sjfq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam int KEY_W = 16;
   localparam int ID_W  = 8;
   localparam int OCC_W = 5;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_POP    = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic              req_type;
      logic [KEY_W-1:0]  burst_time;
      logic [ID_W-1:0]   job_id;
   } req_fields_type;

   typedef struct packed {
      logic              pop_valid;
      logic [ID_W-1:0]   head_id;
      logic [KEY_W-1:0]  head_burst;
      logic [1:0]        status;
      logic [OCC_W-1:0]  occupancy;
   } rsp_fields_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_cmd_type;

endpackage

// ----- rtl/core/sjfq_ctrl.sv -----
// controller state machine for the sorted ready queue
`timescale 1ns / 1ps

module sjfq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output sjfq_pkg::ctrl_cmd_type cmd
);

   sjfq_pkg::state_type state_ff;
   sjfq_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sjfq_pkg::ST_IDLE: begin
            if (start) begin
               state_in = sjfq_pkg::ST_EXEC;
            end
         end
         sjfq_pkg::ST_EXEC: begin
            state_in = sjfq_pkg::ST_IDLE;
         end
         default: begin
            state_in = sjfq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy     = 1'b0;
      cmd.load = 1'b0;
      cmd.exec = 1'b0;
      unique case (state_ff)
         sjfq_pkg::ST_IDLE: begin
            cmd.load = start;
         end
         sjfq_pkg::ST_EXEC: begin
            busy     = 1'b1;
            cmd.exec = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sjfq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/core/sjfq_datapath.sv -----
// compare-and-shift cell array and response register for the sorted ready queue
`timescale 1ns / 1ps

module sjfq_datapath #(
   parameter int QUEUE_DEPTH = sjfq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sjfq_pkg::ctrl_cmd_type  cmd,
   input  sjfq_pkg::req_fields_type req_data,
   output logic                    rsp_strobe,
   output sjfq_pkg::rsp_fields_type rsp_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [sjfq_pkg::KEY_W-1:0] key_ff [QUEUE_DEPTH];
   logic [sjfq_pkg::KEY_W-1:0] key_in [QUEUE_DEPTH];
   logic [sjfq_pkg::ID_W-1:0]  id_ff  [QUEUE_DEPTH];
   logic [sjfq_pkg::ID_W-1:0]  id_in  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]     sel_ff;
   logic [QUEUE_DEPTH-1:0]     sel_in;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   sjfq_pkg::req_fields_type   req_ff;
   sjfq_pkg::rsp_fields_type   rsp_ff;
   sjfq_pkg::rsp_fields_type   rsp_in;
   logic                       rsp_strobe_ff;
   logic                       full;
   logic                       empty;
   logic                       do_insert;
   logic                       do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_insert = cmd.exec && (req_ff.req_type == sjfq_pkg::REQ_INSERT) && !full;
   assign do_pop    = cmd.exec && (req_ff.req_type == sjfq_pkg::REQ_POP) && !empty;

   // per cell: stored key not below the new one, or cell past the tail
   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         assign sel_in[gi] = (key_ff[gi] >= req_data.burst_time) ||
                             (count_ff <= CNT_W'(gi));

         always_comb begin
            key_in[gi] = key_ff[gi];
            id_in[gi]  = id_ff[gi];
            if (do_insert && sel_ff[gi]) begin
               if (gi == 0) begin
                  key_in[gi] = req_ff.burst_time;
                  id_in[gi]  = req_ff.job_id;
               end else if (!sel_ff[(gi == 0) ? 0 : gi - 1]) begin
                  key_in[gi] = req_ff.burst_time;
                  id_in[gi]  = req_ff.job_id;
               end else begin
                  key_in[gi] = key_ff[(gi == 0) ? 0 : gi - 1];
                  id_in[gi]  = id_ff[(gi == 0) ? 0 : gi - 1];
               end
            end else if (do_pop && (gi < QUEUE_DEPTH - 1)) begin
               key_in[gi] = key_ff[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
               id_in[gi]  = id_ff[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
            end
         end
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in            = '0;
      rsp_in.occupancy  = sjfq_pkg::OCC_W'(count_in);
      if (req_ff.req_type == sjfq_pkg::REQ_INSERT) begin
         if (full) begin
            rsp_in.status = sjfq_pkg::STATUS_FULL;
         end else begin
            rsp_in.status = sjfq_pkg::STATUS_OK;
         end
      end else begin
         if (empty) begin
            rsp_in.status = sjfq_pkg::STATUS_EMPTY;
         end else begin
            rsp_in.status     = sjfq_pkg::STATUS_OK;
            rsp_in.pop_valid  = 1'b1;
            rsp_in.head_id    = id_ff[0];
            rsp_in.head_burst = key_ff[0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
         sel_ff <= sel_in;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         key_ff[i] <= key_in[i];
         id_ff[i]  <= id_in[i];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.exec;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- rtl/core/sjf_sorted_ready_queue.sv -----
// shortest-job-first ready queue: top level
// the request is captured in req_ff on load; in the exec state the response is registered
// into rsp_ff together with the response strobe. No new request is taken while busy;
// busy is high in the exec state, in which the cell array shifts after the compare on load
// reset: synchronous, empties the queue and drops any request in flight; stored jobs
// are not cleared
`timescale 1ns / 1ps

module sjf_sorted_ready_queue #(
   parameter int QUEUE_DEPTH = sjfq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  sjfq_pkg::req_fields_type req_data,
   output logic                     rsp_strobe,
   output sjfq_pkg::rsp_fields_type rsp_data
);

   sjfq_pkg::ctrl_cmd_type cmd;

   sjfq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   sjfq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- verif/sjf_sorted_ready_queue_test.sv -----
// self-checking testbench for the shortest-job-first ready queue
`timescale 1ns / 1ps

module sjf_sorted_ready_queue_test;
   import sjfq_pkg::*;

   localparam int DEPTH          = QUEUE_DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS   = 750;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      req_fields_type req;
      bit             typed;
      rsp_fields_type rsp;
   } dir_row_t;

   logic           clock;
   logic           reset;
   logic           start;
   logic           busy;
   req_fields_type req_data;
   logic           rsp_strobe;
   rsp_fields_type rsp_data;

   logic [KEY_W-1:0] jobq_key [DEPTH];
   logic [ID_W-1:0]  jobq_id  [DEPTH];
   int               jobq_count;

   rsp_fields_type pending_rsp [$];
   dir_row_t       dir_rows [$];
   int             error_count;
   int             idle_cycles;

   sjf_sorted_ready_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic rsp_fields_type sjf_apply(req_fields_type r);
      rsp_fields_type o;
      int             pos;
      bit             found;
      o     = '0;
      found = 1'b0;
      if (r.req_type == REQ_INSERT) begin
         if (jobq_count >= DEPTH) begin
            o.status = STATUS_FULL;
         end else begin
            pos = jobq_count;
            for (int i = 0; i < jobq_count; i++) begin
               if (!found && jobq_key[i] >= r.burst_time) begin
                  pos   = i;
                  found = 1'b1;
               end
            end
            for (int i = jobq_count; i > pos; i--) begin
               jobq_key[i] = jobq_key[i-1];
               jobq_id[i]  = jobq_id[i-1];
            end
            jobq_key[pos] = r.burst_time;
            jobq_id[pos]  = r.job_id;
            jobq_count++;
            o.status = STATUS_OK;
         end
      end else begin
         if (jobq_count == 0) begin
            o.status = STATUS_EMPTY;
         end else begin
            o.pop_valid  = 1'b1;
            o.head_id    = jobq_id[0];
            o.head_burst = jobq_key[0];
            for (int i = 1; i < jobq_count; i++) begin
               jobq_key[i-1] = jobq_key[i];
               jobq_id[i-1]  = jobq_id[i];
            end
            jobq_count--;
            o.status = STATUS_OK;
         end
      end
      o.occupancy = OCC_W'(jobq_count);
      return o;
   endfunction

   function automatic rsp_fields_type mk_rsp(logic v, logic [ID_W-1:0] id,
                                             logic [KEY_W-1:0] b, status_type s, int occ);
      rsp_fields_type o;
      o.pop_valid  = v;
      o.head_id    = id;
      o.head_burst = b;
      o.status     = s;
      o.occupancy  = OCC_W'(occ);
      return o;
   endfunction

   function automatic void add_row(logic op, logic [KEY_W-1:0] b, logic [ID_W-1:0] id,
                                   bit typed, rsp_fields_type rsp);
      dir_row_t row;
      row.req.req_type   = op;
      row.req.burst_time = b;
      row.req.job_id     = id;
      row.typed          = typed;
      row.rsp            = rsp;
      dir_rows.push_back(row);
   endfunction

   function automatic int rand_gap(bit gaps_on);
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // hold start until the request is taken, then record the expected response
   task automatic issue(req_fields_type r, bit typed, rsp_fields_type fixed, int gap);
      rsp_fields_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predicted = sjf_apply(r);
      pending_rsp.push_back(typed ? fixed : predicted);
   endtask

   always @(posedge clock) begin
      rsp_fields_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_strobe) begin
            if (pending_rsp.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("unexpected response: valid=%0d id=%0d burst=%0d status=%0d occ=%0d",
                           rsp_data.pop_valid, rsp_data.head_id, rsp_data.head_burst,
                           rsp_data.status, rsp_data.occupancy);
               end
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.pop_valid !== want.pop_valid || rsp_data.head_id !== want.head_id
                   || rsp_data.head_burst !== want.head_burst
                   || rsp_data.status !== want.status
                   || rsp_data.occupancy !== want.occupancy) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("mismatch: expected valid=%0d id=%0d burst=%0d status=%0d occ=%0d",
                              want.pop_valid, want.head_id, want.head_burst, want.status,
                              want.occupancy);
                     $display("          got      valid=%0d id=%0d burst=%0d status=%0d occ=%0d",
                              rsp_data.pop_valid, rsp_data.head_id, rsp_data.head_burst,
                              rsp_data.status, rsp_data.occupancy);
                  end
               end
            end
         end
         if (rsp_strobe || (start && !busy)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      req_fields_type r;
      int             issued;
      int             seg_len;
      int             pop_pct;
      int             key_mode;
      bit             gaps_on;
      error_count = 0;
      jobq_count  = 0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;

      add_row(REQ_POP,    16'h0000, 8'h00, 1'b1, mk_rsp(1'b0, 0, 0, STATUS_EMPTY, 0));
      add_row(REQ_INSERT, 16'h0000, 8'h00, 1'b1, mk_rsp(1'b0, 0, 0, STATUS_OK, 1));
      add_row(REQ_INSERT, 16'hffff, 8'hff, 1'b1, mk_rsp(1'b0, 0, 0, STATUS_OK, 2));
      add_row(REQ_INSERT, 16'd100,  8'h01, 1'b0, '0);
      add_row(REQ_INSERT, 16'd100,  8'h02, 1'b0, '0);
      add_row(REQ_POP,    16'h0000, 8'h00, 1'b1, mk_rsp(1'b1, 0, 0, STATUS_OK, 3));
      // equal burst times: newest job comes out first
      add_row(REQ_POP,    16'h0000, 8'h00, 1'b0, '0);
      for (int i = 0; i < DEPTH - 2; i++) begin
         add_row(REQ_INSERT, KEY_W'(16'h8000 ^ (i * 16'h1357)), ID_W'(8'h10 + i), 1'b0, '0);
      end
      add_row(REQ_INSERT, 16'hffff, 8'haa, 1'b1, mk_rsp(1'b0, 0, 0, STATUS_FULL, DEPTH));
      add_row(REQ_POP,    16'hffff, 8'hff, 1'b0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[k]) begin
         issue(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].rsp, rand_gap(1'b1));
      end

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         seg_len  = $urandom_range(20, 60);
         case ($urandom_range(0, 2))
            0: begin
               pop_pct = 15;
            end
            1: begin
               pop_pct = 50;
            end
            default: begin
               pop_pct = 85;
            end
         endcase
         key_mode = $urandom_range(0, 2);
         gaps_on  = ($urandom_range(0, 3) != 0);
         for (int j = 0; j < seg_len && issued < RANDOM_ITEMS; j++) begin
            r.req_type = ($urandom_range(0, 99) < pop_pct) ? REQ_POP : REQ_INSERT;
            case (key_mode)
               0: begin
                  r.burst_time = KEY_W'($urandom);
               end
               1: begin
                  r.burst_time = KEY_W'($urandom_range(0, 7));
               end
               default: begin
                  case ($urandom_range(0, 2))
                     0: begin
                        r.burst_time = '0;
                     end
                     1: begin
                        r.burst_time = '1;
                     end
                     default: begin
                        r.burst_time = KEY_W'($urandom);
                     end
                  endcase
               end
            endcase
            r.job_id = ID_W'($urandom);
            issue(r, 1'b0, '0, rand_gap(gaps_on));
            issued++;
         end
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/sjfq_pkg.sv
rtl/core/sjfq_ctrl.sv
rtl/core/sjfq_datapath.sv
rtl/core/sjf_sorted_ready_queue.sv
verif/sjf_sorted_ready_queue_test.sv
